/* src/utf8_token_decoder_core_assert.svh */
// ----------------------------------------------------------------------------
// utf8 token decoder assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef UTF8_TOKEN_DECODER_CORE_ASSERT_SVH
`define UTF8_TOKEN_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define UTD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("utd assertion failed");
`define UTD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("utd assertion failed");
`else
`define UTD_ASSERT(label, clk, rst, prop)
`define UTD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/utd_pkg.sv */
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants of the utf8 token decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

  typedef enum logic [2:0] {
    KIND_END         = 3'd0,
    KIND_CONTROL     = 3'd1,
    KIND_SCALAR      = 3'd2,
    KIND_EXT_CONTROL = 3'd3,
    KIND_INVALID     = 3'd4
  } kind_t;

  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_EXT_LEAD = 8'h80;
  localparam logic [7:0] BYTE_2_LO     = 8'hC2;
  localparam logic [7:0] BYTE_2_HI     = 8'hDF;
  localparam logic [7:0] BYTE_3_LO     = 8'hE0;
  localparam logic [7:0] BYTE_3_HI     = 8'hEF;
  localparam logic [7:0] BYTE_3_SURR   = 8'hED;
  localparam logic [7:0] BYTE_3_MIN    = 8'hA0;
  localparam logic [7:0] BYTE_4_LO     = 8'hF0;
  localparam logic [7:0] BYTE_4_HI     = 8'hF4;
  localparam logic [7:0] BYTE_4_MIN    = 8'h90;
  localparam logic [7:0] BYTE_4_MAX    = 8'h8F;
  localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;

  typedef struct packed {
    logic load;
    logic take;
    logic send;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic decided;
    logic out_free;
  } stat_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] cp;
    logic [2:0]  len;
    logic [7:0]  ctl;
    logic [7:0]  pay;
  } token_t;

endpackage

/* src/utd_ctrl.sv */
// ----------------------------------------------------------------------------
// utd_ctrl
// Sequencer: accepts a byte, cuts window tokens one per cycle unless output stalls.
// ----------------------------------------------------------------------------
module utd_ctrl
  import utd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FIRST = 3'b010,
    S_CHAIN = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (stat.decided) begin
          cmd.take   = 1'b1;
          state_next = S_CHAIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHAIN: begin
        if (stat.out_free) begin
          cmd.send = 1'b1;
          cmd.last = !stat.decided;
          if (stat.decided) begin
            cmd.take = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/utd_datapath.sv */
// ----------------------------------------------------------------------------
// utd_datapath
// Byte window, token decoder, held token and output register.
// ----------------------------------------------------------------------------
`include "utf8_token_decoder_core_assert.svh"

module utd_datapath
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [20:0] code_point,
  output logic [2:0]  byte_length,
  output logic [7:0]  control_code,
  output logic [7:0]  payload_byte,
  output logic        last_of_run
);

  logic [3:0][7:0] window;
  logic [2:0]      count;
  token_t          held;
  token_t          tok;
  logic            decided;
  logic [2:0]      used;
  logic [3:0][7:0] shifted;
  logic [7:0]      a, b1, b2, b3;
  logic            c1, c2, c3;

  assign a  = window[0];
  assign b1 = window[1];
  assign b2 = window[2];
  assign b3 = window[3];
  assign c1 = (b1 >= BYTE_EXT_LEAD) && (b1 <= BYTE_CONT_HI);
  assign c2 = (b2 >= BYTE_EXT_LEAD) && (b2 <= BYTE_CONT_HI);
  assign c3 = (b3 >= BYTE_EXT_LEAD) && (b3 <= BYTE_CONT_HI);

  // decode the front of the window
  always_comb begin
    tok      = '{kind: KIND_INVALID, cp: '0, len: 3'd1, ctl: '0, pay: '0};
    used     = 3'd1;
    decided  = (count != 3'd0);
    priority if (a == 8'h00) begin
      tok.kind = KIND_END;
      tok.len  = 3'd0;
      used     = count;
    end else if (a < BYTE_SPACE) begin
      tok.kind = KIND_CONTROL;
      tok.ctl  = a;
    end else if (a < BYTE_EXT_LEAD) begin
      tok.kind = KIND_SCALAR;
      tok.cp   = {14'd0, a[6:0]};
    end else if (a == BYTE_EXT_LEAD) begin
      if (count < 3'd2) begin
        decided = 1'b0;
      end else if (b1 != 8'h00) begin
        tok.kind = KIND_EXT_CONTROL;
        tok.len  = 3'd2;
        tok.ctl  = a;
        tok.pay  = b1;
        used     = 3'd2;
      end
    end else if ((a >= BYTE_2_LO) && (a <= BYTE_2_HI)) begin
      if (count < 3'd2) begin
        decided = 1'b0;
      end else if (c1) begin
        tok.kind = KIND_SCALAR;
        tok.cp   = {10'd0, a[4:0], b1[5:0]};
        tok.len  = 3'd2;
        used     = 3'd2;
      end
    end else if ((a >= BYTE_3_LO) && (a <= BYTE_3_HI)) begin
      if (count < 3'd2) begin
        decided = 1'b0;
      end else if (c1 && !((a == BYTE_3_LO) && (b1 < BYTE_3_MIN)) &&
                   !((a == BYTE_3_SURR) && (b1 >= BYTE_3_MIN))) begin
        if (count < 3'd3) begin
          decided = 1'b0;
        end else if (c2) begin
          tok.kind = KIND_SCALAR;
          tok.cp   = {5'd0, a[3:0], b1[5:0], b2[5:0]};
          tok.len  = 3'd3;
          used     = 3'd3;
        end
      end
    end else if ((a >= BYTE_4_LO) && (a <= BYTE_4_HI)) begin
      if (count < 3'd2) begin
        decided = 1'b0;
      end else if (c1 && !((a == BYTE_4_LO) && (b1 < BYTE_4_MIN)) &&
                   !((a == BYTE_4_HI) && (b1 > BYTE_4_MAX))) begin
        if (count < 3'd3) begin
          decided = 1'b0;
        end else if (c2) begin
          if (count < 3'd4) begin
            decided = 1'b0;
          end else if (c3) begin
            tok.kind = KIND_SCALAR;
            tok.cp   = {a[2:0], b1[5:0], b2[5:0], b3[5:0]};
            tok.len  = 3'd4;
            used     = 3'd4;
          end
        end
      end
    end
  end

  always_comb begin
    unique case (used)
      3'd1:    shifted = {8'h00, window[3], window[2], window[1]};
      3'd2:    shifted = {16'h0000, window[3], window[2]};
      3'd3:    shifted = {24'h000000, window[3]};
      default: shifted = '0;
    endcase
  end

  assign stat.decided  = decided;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (cmd.load) begin
      count <= count + 3'd1;
    end else if (cmd.take) begin
      count <= count - used;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      window[count[1:0]] <= in_byte;
    end else if (cmd.take) begin
      window <= shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held <= tok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.send) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      token_kind   <= held.kind;
      code_point   <= held.cp;
      byte_length  <= held.len;
      control_code <= held.ctl;
      payload_byte <= held.pay;
      last_of_run  <= cmd.last;
    end
  end

  `UTD_ASSERT(a_load_room, clk, rst, cmd.load |-> count <= 3'd3)
  `UTD_ASSERT(a_take_decided, clk, rst, cmd.take |-> stat.decided && used <= count)
  `UTD_ASSERT(a_send_free, clk, rst, cmd.send |-> stat.out_free)
  `UTD_ASSERT(a_end_empties, clk, rst,
    (cmd.take && tok.kind == KIND_END) |=> count == 3'd0)

endmodule

/* src/utf8_token_decoder_core.sv */
// ----------------------------------------------------------------------------
// utf8_token_decoder_core
// Byte-in, token-out utf8 decoder with validation.
// ----------------------------------------------------------------------------
// One byte is taken per request and appended to a window of at most four
// undecided bytes; tokens are then cut from the front of the window, one per
// cycle while the output is free, by a single decoder. A byte that gives no
// token keeps in_ready low until the sequencer is back in idle; a byte can
// give up to four tokens (after an invalid sequence is replayed), each taken
// into the held token and then sent through the output register; a stalled
// output holds the chain. The final token of each byte carries last_of_run.
// ----------------------------------------------------------------------------
module utf8_token_decoder_core
  import utd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [20:0] code_point,
  output logic [2:0]  byte_length,
  output logic [7:0]  control_code,
  output logic [7:0]  payload_byte,
  output logic        last_of_run
);

  cmd_t  cmd;
  stat_t stat;

  utd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  utd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .code_point   (code_point),
    .byte_length  (byte_length),
    .control_code (control_code),
    .payload_byte (payload_byte),
    .last_of_run  (last_of_run)
  );

endmodule
